FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define CKT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define CKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ckt_pkg.sv
// Shared constants, codes and types of the client keepalive table.
// No dependencies; imported by every module of the block.
package ckt_pkg;

  localparam int CLIENT_SLOTS = 2;
  localparam int SLOT_IDX_W   = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

  localparam logic [SLOT_IDX_W-1:0] PTR_LAST = SLOT_IDX_W'(CLIENT_SLOTS - 1);
  localparam logic [4:0]            SLOT_LIMIT = 5'(CLIENT_SLOTS);

  // opcodes
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_PONG   = 3'd3;
  localparam logic [2:0] OP_TOPICS = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PING_INTERVAL  = 2'd0;
  localparam logic [1:0] CFG_MISS_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_TOPICS = 2'd2;

  localparam logic [31:0] RST_PING_INTERVAL  = 32'd10000;
  localparam logic [7:0]  RST_MISS_LIMIT     = 8'd2;
  localparam logic [6:0]  RST_DEFAULT_TOPICS = 7'd127;

  // slot store write kinds
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_ADD    = 3'd1;
  localparam logic [2:0] WR_FREE   = 3'd2;
  localparam logic [2:0] WR_MISSED = 3'd3;
  localparam logic [2:0] WR_TOPICS = 3'd4;
  localparam logic [2:0] WR_PING   = 3'd5;

  typedef struct packed {
    logic [31:0] ping_interval;
    logic [7:0]  miss_limit;
    logic [6:0]  default_topics;
  } cfg_t;

  typedef struct packed {
    logic        in_use;
    logic [6:0]  topics;
    logic [63:0] last_ping;
    logic [7:0]  missed;
  } slot_rd_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [SLOT_IDX_W-1:0] idx;
    logic [6:0]            topics;
    logic [63:0]           now;
    logic [7:0]            missed;
  } slot_wr_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] result_slot;
    logic       ping_due;
    logic [4:0] client_count;
    logic [6:0] slot_topics;
    logic       expired;
    logic       last;
  } res_t;

endpackage

FILE: rtl/core/ckt_in_if.sv
// Command channel of the client keepalive table.
// No dependencies.
interface ckt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  slot;
  logic [63:0] now_ms;
  logic [6:0]  topic_mask;

  modport source (output valid, output opcode, output slot, output now_ms,
                  output topic_mask, input ready);
  modport sink (input valid, input opcode, input slot, input now_ms,
                input topic_mask, output ready);
endinterface

FILE: rtl/core/ckt_out_if.sv
// Result channel of the client keepalive table.
// No dependencies.
interface ckt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] result_slot;
  logic       ping_due;
  logic [4:0] client_count;
  logic [6:0] slot_topics;
  logic       expired;
  logic       last;

  modport source (output valid, output status, output result_slot, output ping_due,
                  output client_count, output slot_topics, output expired,
                  output last, input ready);
  modport sink (input valid, input status, input result_slot, input ping_due,
                input client_count, input slot_topics, input expired,
                input last, output ready);
endinterface

FILE: rtl/core/ckt_cfg_if.sv
// Configuration write channel of the client keepalive table.
// No dependencies.
interface ckt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ckt_store.sv
// Per-slot state of the keepalive table: use bits, topic masks, ping times, miss counts.
// Depends on ckt_pkg.
module ckt_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ckt_pkg::slot_wr_t                 wr,
  input  logic [ckt_pkg::SLOT_IDX_W-1:0]    rd_idx,
  output ckt_pkg::slot_rd_t                 rd
);
  import ckt_pkg::*;

  logic [CLIENT_SLOTS-1:0] in_use_r;
  logic [6:0]              topics_r [CLIENT_SLOTS];
  logic [63:0]             last_r   [CLIENT_SLOTS];
  logic [7:0]              missed_r [CLIENT_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else begin
      case (wr.kind)
        WR_ADD:  in_use_r[wr.idx] <= 1'b1;
        WR_FREE: in_use_r[wr.idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (wr.kind)
      WR_ADD: begin
        topics_r[wr.idx] <= wr.topics;
        last_r[wr.idx]   <= wr.now;
        missed_r[wr.idx] <= wr.missed;
      end
      WR_MISSED: missed_r[wr.idx] <= wr.missed;
      WR_TOPICS: topics_r[wr.idx] <= wr.topics;
      WR_PING: begin
        last_r[wr.idx]   <= wr.now;
        missed_r[wr.idx] <= wr.missed;
      end
      default: ;
    endcase
  end

  assign rd.in_use    = in_use_r[rd_idx];
  assign rd.topics    = topics_r[rd_idx];
  assign rd.last_ping = last_r[rd_idx];
  assign rd.missed    = missed_r[rd_idx];

endmodule

FILE: rtl/core/ckt_due_unit.sv
// Shared elapsed-time compare: is a slot's ping due at the current time.
// Depends on ckt_pkg.
module ckt_due_unit (
  input  ckt_pkg::slot_rd_t rd,
  input  logic [63:0]       now,
  input  logic [31:0]       interval,
  output logic              due
);
  import ckt_pkg::*;

  logic [63:0] elapsed;

  // elapsed wraps modulo 2^64; interval fits in the low word
  assign elapsed = now - rd.last_ping;
  assign due     = rd.in_use && ((|elapsed[63:32]) || (elapsed[31:0] >= interval));

endmodule

FILE: rtl/core/ckt_ctrl.sv
// Keepalive table sequencer: walks slots one per cycle unless stalled, drives the
// store and due unit and holds results in an output register. Depends on ckt_pkg.
module ckt_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  ckt_in_if.sink                            in_ch,
  ckt_out_if.source                         out_ch,
  input  ckt_pkg::cfg_t                     cfg,
  input  ckt_pkg::slot_rd_t                 rd,
  input  logic                              due,
  output logic [ckt_pkg::SLOT_IDX_W-1:0]    rd_idx,
  output ckt_pkg::slot_wr_t                 wr,
  output logic [63:0]                       now
);
  import ckt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SLOT = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_TEND = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [3:0]            slot_r, slot_nxt;
  logic [63:0]           now_r, now_nxt;
  logic [6:0]            mask_r, mask_nxt;
  logic [SLOT_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic                  pend_v_r, pend_v_nxt;
  res_t                  pend_r, pend_nxt;
  logic                  out_v_r, out_v_nxt;
  res_t                  out_r, out_nxt;
  res_t                  res;
  logic                  push;
  logic                  adv;
  logic                  can_push;
  logic                  slot_ok;
  logic [7:0]            miss_sat;

  assign can_push = !out_v_r || out_ch.ready;
  assign rd_idx   = (state_r == S_SLOT) ? slot_r[SLOT_IDX_W-1:0] : ptr_r;
  assign slot_ok  = ({1'b0, slot_r} < SLOT_LIMIT) && rd.in_use;
  assign miss_sat = (rd.missed == 8'hFF) ? 8'hFF : rd.missed + 8'd1;
  assign now      = now_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    slot_nxt   = slot_r;
    now_nxt    = now_r;
    mask_nxt   = mask_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    push       = 1'b0;
    adv        = 1'b0;
    res        = '0;
    res.client_count = cnt_r;
    res.last   = 1'b1;
    wr.kind    = WR_NONE;
    wr.idx     = rd_idx;
    wr.topics  = cfg.default_topics;
    wr.now     = now_r;
    wr.missed  = 8'd0;

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.opcode;
          slot_nxt   = in_ch.slot;
          now_nxt    = in_ch.now_ms;
          mask_nxt   = in_ch.topic_mask;
          ptr_nxt    = '0;
          pend_v_nxt = 1'b0;
          case (in_ch.opcode)
            OP_ADD:  state_nxt = S_ADD;
            OP_TICK: state_nxt = S_TICK;
            OP_REMOVE, OP_PONG, OP_TOPICS, OP_QUERY: state_nxt = S_SLOT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SLOT: begin
        if (can_push) begin
          push            = 1'b1;
          state_nxt       = S_IDLE;
          res.result_slot = slot_r;
          if (!slot_ok) begin
            res.status = ST_BAD;
          end else begin
            case (op_r)
              OP_REMOVE: begin
                wr.kind          = WR_FREE;
                cnt_nxt          = cnt_r - 5'd1;
                res.client_count = cnt_r - 5'd1;
              end
              OP_PONG: begin
                wr.kind         = WR_MISSED;
                res.slot_topics = rd.topics;
              end
              OP_TOPICS: begin
                wr.kind         = WR_TOPICS;
                wr.topics       = mask_r;
                res.slot_topics = mask_r;
                res.expired     = rd.missed > cfg.miss_limit;
              end
              default: begin
                res.slot_topics = rd.topics;
                res.expired     = rd.missed > cfg.miss_limit;
              end
            endcase
          end
        end
      end

      S_ADD: begin
        if (!rd.in_use) begin
          if (can_push) begin
            wr.kind          = WR_ADD;
            cnt_nxt          = cnt_r + 5'd1;
            push             = 1'b1;
            res.result_slot  = 4'(ptr_r);
            res.client_count = cnt_r + 5'd1;
            res.slot_topics  = cfg.default_topics;
            state_nxt        = S_IDLE;
          end
        end else if (ptr_r == PTR_LAST) begin
          if (can_push) begin
            push       = 1'b1;
            res.status = ST_FULL;
            state_nxt  = S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + SLOT_IDX_W'(1);
        end
      end

      S_TICK: begin
        if (due) begin
          // hold the latest ping result back so the final one can carry last
          if (!pend_v_r || can_push) begin
            if (pend_v_r) begin
              push = 1'b1;
              res  = pend_r;
            end
            wr.kind               = WR_PING;
            wr.missed             = miss_sat;
            pend_v_nxt            = 1'b1;
            pend_nxt              = '0;
            pend_nxt.result_slot  = 4'(ptr_r);
            pend_nxt.ping_due     = 1'b1;
            pend_nxt.client_count = cnt_r;
            pend_nxt.slot_topics  = rd.topics;
            pend_nxt.expired      = miss_sat > cfg.miss_limit;
            adv                   = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
        if (adv) begin
          if (ptr_r == PTR_LAST) begin
            state_nxt = S_TEND;
          end else begin
            ptr_nxt = ptr_r + SLOT_IDX_W'(1);
          end
        end
      end

      S_TEND: begin
        if (can_push) begin
          push = 1'b1;
          if (pend_v_r) begin
            res      = pend_r;
            res.last = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push) begin
      out_v_nxt = 1'b1;
      out_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= 5'd0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    slot_r <= slot_nxt;
    now_r  <= now_nxt;
    mask_r <= mask_nxt;
    ptr_r  <= ptr_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.result_slot  = out_r.result_slot;
  assign out_ch.ping_due     = out_r.ping_due;
  assign out_ch.client_count = out_r.client_count;
  assign out_ch.slot_topics  = out_r.slot_topics;
  assign out_ch.expired      = out_r.expired;
  assign out_ch.last         = out_r.last;

endmodule

FILE: rtl/core/client_keepalive_table_top.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   opcode, slot, now_ms, topic_mask
// out_ch    out  valid/ready   status, result_slot, ping_due, client_count,
//                              slot_topics, expired, last
// cfg_ch    in   valid/ready   index, data (always ready)
//
// A transaction is taken only while the sequencer is idle; add and tick then visit
// slots one per cycle, tick through the shared elapsed-time compare; remove, pong,
// set-topics and query use the named slot. Input is ready again once the result is
// registered. Reset clears the use bits and client count and loads the reset config.
// A full output register stalls the sequencer until the result is taken.
// Top level: configuration registers and the sequencer, store and due unit.
// Depends on ckt_pkg, the channel interfaces, ckt_ctrl, ckt_store, ckt_due_unit.
module client_keepalive_table_top (
  input  logic       clk,
  input  logic       rst_n,
  ckt_in_if.sink     in_ch,
  ckt_out_if.source  out_ch,
  ckt_cfg_if.sink    cfg_ch
);
  import ckt_pkg::*;

  cfg_t                  cfg_r, cfg_nxt;
  slot_rd_t              rd;
  slot_wr_t              wr;
  logic [SLOT_IDX_W-1:0] rd_idx;
  logic                  due;
  logic [63:0]           now;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PING_INTERVAL:  cfg_nxt.ping_interval  = cfg_ch.data;
        CFG_MISS_LIMIT:     cfg_nxt.miss_limit     = cfg_ch.data[7:0];
        CFG_DEFAULT_TOPICS: cfg_nxt.default_topics = cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ping_interval  <= RST_PING_INTERVAL;
      cfg_r.miss_limit     <= RST_MISS_LIMIT;
      cfg_r.default_topics <= RST_DEFAULT_TOPICS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ckt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_r),
    .rd     (rd),
    .due    (due),
    .rd_idx (rd_idx),
    .wr     (wr),
    .now    (now)
  );

  ckt_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  ckt_due_unit u_due (
    .rd       (rd),
    .now      (now),
    .interval (cfg_r.ping_interval),
    .due      (due)
  );

endmodule

FILE: rtl/core/ckt_checker.sv
// Port-level checker of the client keepalive table and its bind to the top level.
// Depends on ckt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ckt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [3:0] out_result_slot,
  input logic       out_ping_due,
  input logic [4:0] out_client_count,
  input logic       out_last
);
  import ckt_pkg::*;

  `CKT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

  `CKT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_result_slot) && $stable(out_last), "stalled result changed")

  `CKT_ASSERT(a_count_bound, clk, rst_n, out_valid |-> out_client_count <= SLOT_LIMIT, "client count above slot count")

  `CKT_ASSERT(a_ping_ok, clk, rst_n, out_valid && out_ping_due |-> out_status == ST_OK, "ping result with error status")

  `CKT_ASSERT(a_err_last, clk, rst_n, out_valid && out_status != ST_OK |-> out_last && !out_ping_due, "error result not single")

endmodule

bind client_keepalive_table_top ckt_checker u_ckt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_result_slot  (out_ch.result_slot),
  .out_ping_due     (out_ch.ping_due),
  .out_client_count (out_ch.client_count),
  .out_last         (out_ch.last)
);

FILE: verif/testbench.sv
// Self-checking testbench for client_keepalive_table_top: directed table, then random
// command streams under random back-pressure, checked against a built-in slot table model.
// Depends on ckt_pkg and the ckt_in_if / ckt_out_if / ckt_cfg_if channel interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ckt_pkg::*;

  localparam int SETTLE_CYCLES = CLIENT_SLOTS + 6;
  localparam int HOLD_CYCLES   = 60;
  localparam int MAX_REPORTS   = 10;
  localparam int ZERO_TICKS    = 12;
  localparam int PHASE_ITEMS   = 20;

  // opcodes the block must ignore
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [63:0] now;
    logic [6:0]  mask;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ckt_in_if  cmd_bus ();
  ckt_out_if res_bus ();
  ckt_cfg_if cfg_bus ();

  client_keepalive_table_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow of the client table and its registers
  logic        slot_used   [CLIENT_SLOTS];
  logic [6:0]  slot_mask   [CLIENT_SLOTS];
  logic [63:0] slot_stamp  [CLIENT_SLOTS];
  logic [7:0]  slot_missed [CLIENT_SLOTS];
  logic [31:0] cur_ping_interval;
  logic [7:0]  cur_miss_limit;
  logic [6:0]  cur_default_topics;

  res_t        expected_results [$];
  logic [63:0] clock_ms;

  int mismatches;
  int results_seen;
  int ping_results;
  int items_sent;
  int directed_items;
  bit quiet;
  bit hold_sink;
  bit saturated_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [4:0] clients_in_use();
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < CLIENT_SLOTS; i++) n += 5'(slot_used[i]);
    return n;
  endfunction

  function automatic logic lapsed(int s);
    return slot_used[s] && (slot_missed[s] > cur_miss_limit);
  endfunction

  function automatic res_t outcome(logic [1:0] st, logic [3:0] sl, logic due, logic [4:0] cnt,
                                   logic [6:0] top, logic stale, logic fin);
    res_t r;
    r.status       = st;
    r.result_slot  = sl;
    r.ping_due     = due;
    r.client_count = cnt;
    r.slot_topics  = top;
    r.expired      = stale;
    r.last         = fin;
    return r;
  endfunction

  // Apply one command to the shadow table and queue the results it causes.
  function automatic void predict_table_op(logic [2:0] op, logic [3:0] slot, logic [63:0] now,
                                           logic [6:0] mask);
    int          hits;
    bit          placed;
    logic [63:0] elapsed;
    hits   = 0;
    placed = 1'b0;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < CLIENT_SLOTS && !placed; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]   = 1'b1;
            slot_mask[i]   = cur_default_topics;
            slot_stamp[i]  = now;
            slot_missed[i] = '0;
            placed         = 1'b1;
            expected_results.push_back(outcome(ST_OK, 4'(i), 1'b0, clients_in_use(),
                                               slot_mask[i], lapsed(i), 1'b1));
          end
        end
        if (!placed)
          expected_results.push_back(outcome(ST_FULL, '0, 1'b0, clients_in_use(), '0, 1'b0, 1'b1));
      end
      OP_TICK: begin
        for (int i = 0; i < CLIENT_SLOTS; i++) begin
          elapsed = now - slot_stamp[i];
          if (slot_used[i] && elapsed >= {32'd0, cur_ping_interval}) begin
            slot_stamp[i] = now;
            if (slot_missed[i] != 8'hFF) slot_missed[i]++;
            if (slot_missed[i] == 8'hFF) saturated_seen = 1'b1;
            expected_results.push_back(outcome(ST_OK, 4'(i), 1'b1, clients_in_use(),
                                               slot_mask[i], lapsed(i), 1'b0));
            hits++;
          end
        end
        if (hits == 0)
          expected_results.push_back(outcome(ST_OK, '0, 1'b0, clients_in_use(), '0, 1'b0, 1'b1));
        else
          expected_results[expected_results.size() - 1].last = 1'b1;
      end
      OP_REMOVE, OP_PONG, OP_TOPICS, OP_QUERY: begin
        if (int'(slot) >= CLIENT_SLOTS || !slot_used[slot]) begin
          expected_results.push_back(outcome(ST_BAD, slot, 1'b0, clients_in_use(), '0, 1'b0, 1'b1));
        end else if (op == OP_REMOVE) begin
          slot_used[slot] = 1'b0;
          expected_results.push_back(outcome(ST_OK, slot, 1'b0, clients_in_use(), '0, 1'b0, 1'b1));
        end else begin
          if (op == OP_PONG) slot_missed[slot] = '0;
          if (op == OP_TOPICS) slot_mask[slot] = mask;
          expected_results.push_back(outcome(ST_OK, slot, 1'b0, clients_in_use(), slot_mask[slot],
                                             lapsed(int'(slot)), 1'b1));
        end
      end
      default: ;  // reserved opcodes: no result, no change
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic stim_row_t row(logic [2:0] op, logic [3:0] sl, logic [63:0] t,
                                    logic [6:0] m, bit typed = 1'b0, res_t want = '0);
    stim_row_t s;
    s.op    = op;
    s.slot  = sl;
    s.now   = t;
    s.mask  = m;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  task automatic drop_cmd();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
  endtask

  // Offer one command; valid stays high after acceptance until drop_cmd or the next command.
  task automatic send_cmd(logic [2:0] op, logic [3:0] sl, logic [63:0] t, logic [6:0] m,
                          int gap, bit typed = 1'b0, res_t want = '0);
    if (gap > 0) begin
      drop_cmd();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_bus.valid      <= 1'b1;
    cmd_bus.opcode     <= op;
    cmd_bus.slot       <= sl;
    cmd_bus.now_ms     <= t;
    cmd_bus.topic_mask <= m;
    do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
    predict_table_op(op, sl, t, m);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
    items_sent++;
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    case (idx)
      CFG_PING_INTERVAL:  cur_ping_interval  = val;
      CFG_MISS_LIMIT:     cur_miss_limit     = val[7:0];
      CFG_DEFAULT_TOPICS: cur_default_topics = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold the sender until every result is in, then let the sequencer finish its scan.
  task automatic settle();
    drop_cmd();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(logic [31:0] interval, logic [7:0] limit, logic [6:0] topics);
    settle();
    write_cfg(CFG_PING_INTERVAL, interval);
    write_cfg(CFG_MISS_LIMIT, {24'd0, limit});
    write_cfg(CFG_DEFAULT_TOPICS, {25'd0, topics});
  endtask

  // Well-formed traffic with advancing time; a small share of bad slots, stray times and
  // reserved opcodes. With squeeze set the sink holds off while commands keep coming.
  task automatic random_phase(int items, bit squeeze);
    int          pick;
    int          gap;
    logic [2:0]  op;
    logic [3:0]  sl;
    logic [63:0] step;
    logic [63:0] t;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18)      op = OP_ADD;
      else if (pick < 28) op = OP_REMOVE;
      else if (pick < 58) op = OP_TICK;
      else if (pick < 73) op = OP_PONG;
      else if (pick < 85) op = OP_TOPICS;
      else if (pick < 95) op = OP_QUERY;
      else                op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
      if ($urandom_range(0, 9) == 0) sl = 4'($urandom_range(0, 15));
      else                           sl = 4'($urandom_range(0, CLIENT_SLOTS - 1));
      if (cur_ping_interval <= 32'd1000)
        step = 64'($urandom_range(0, 2 * int'(cur_ping_interval)));
      else
        step = {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
      clock_ms += step;
      t = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_ms;
      gap = (squeeze || quiet) ? 0 : idle_len();
      if (squeeze && k == items / 4) hold_sink = 1'b1;
      send_cmd(op, sl, t, 7'($urandom), gap);
    end
  endtask

  initial begin : result_sink
    int off_left;
    off_left      = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        hold_sink = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (off_left > 0) begin
        res_bus.ready <= 1'b0;
        off_left--;
      end else begin
        res_bus.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) off_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got = outcome(res_bus.status, res_bus.result_slot, res_bus.ping_due, res_bus.client_count,
                    res_bus.slot_topics, res_bus.expired, res_bus.last);
      results_seen++;
      if (got.ping_due) ping_results++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result st=%0d slot=%0d due=%0d cnt=%0d top=%h exp=%0d last=%0d",
                   $time, got.status, got.result_slot, got.ping_due, got.client_count,
                   got.slot_topics, got.expired, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch expected st=%0d slot=%0d due=%0d cnt=%0d top=%h exp=%0d last=%0d",
                     $time, want.status, want.result_slot, want.ping_due, want.client_count,
                     want.slot_topics, want.expired, want.last);
            $display("%0t:          actual   st=%0d slot=%0d due=%0d cnt=%0d top=%h exp=%0d last=%0d",
                     $time, got.status, got.result_slot, got.ping_due, got.client_count,
                     got.slot_topics, got.expired, got.last);
          end
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t plan [$];
    cmd_bus.valid      = 1'b0;
    cmd_bus.opcode     = OP_ADD;
    cmd_bus.slot       = '0;
    cmd_bus.now_ms     = '0;
    cmd_bus.topic_mask = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_PING_INTERVAL;
    cfg_bus.data       = '0;
    rst_n              = 1'b0;
    quiet              = 1'b0;
    hold_sink          = 1'b0;
    saturated_seen     = 1'b0;
    mismatches         = 0;
    results_seen       = 0;
    ping_results       = 0;
    items_sent         = 0;
    cur_ping_interval  = RST_PING_INTERVAL;
    cur_miss_limit     = RST_MISS_LIMIT;
    cur_default_topics = RST_DEFAULT_TOPICS;
    for (int i = 0; i < CLIENT_SLOTS; i++) begin
      slot_used[i]   = 1'b0;
      slot_mask[i]   = '0;
      slot_stamp[i]  = '0;
      slot_missed[i] = '0;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, fill, full, bad slots, ignored opcodes, time wrap,
    // expiry, pong, remove and reuse.
    plan.push_back(row(OP_QUERY, 4'd0, '0, '0, 1'b1,
                       outcome(ST_BAD, 4'd0, 1'b0, 5'd0, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_TICK, 4'd0, '0, '0, 1'b1,
                       outcome(ST_OK, 4'd0, 1'b0, 5'd0, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_ADD, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1'b1,
                       outcome(ST_OK, 4'd0, 1'b0, 5'd1, 7'h7F, 1'b0, 1'b1)));
    plan.push_back(row(OP_ADD, 4'd0, '0, '0, 1'b1,
                       outcome(ST_OK, 4'd1, 1'b0, 5'd2, 7'h7F, 1'b0, 1'b1)));
    plan.push_back(row(OP_ADD, 4'd0, '0, '0, 1'b1,
                       outcome(ST_FULL, 4'd0, 1'b0, 5'd2, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_QUERY, 4'd15, '0, '0, 1'b1,
                       outcome(ST_BAD, 4'd15, 1'b0, 5'd2, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_PONG, 4'd2, '0, '0, 1'b1,
                       outcome(ST_BAD, 4'd2, 1'b0, 5'd2, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_RSVD6, 4'd15, '1, 7'h7F));
    plan.push_back(row(OP_RSVD7, 4'd0, '1, 7'h7F));
    plan.push_back(row(OP_TICK, 4'd0, 64'd9999, '0));
    plan.push_back(row(OP_TOPICS, 4'd0, '0, 7'h00));
    plan.push_back(row(OP_TOPICS, 4'd1, '0, 7'h55));
    plan.push_back(row(OP_TICK, 4'd0, 64'd20000, '0));
    plan.push_back(row(OP_TICK, 4'd0, 64'd30001, '0));
    plan.push_back(row(OP_QUERY, 4'd0, '0, '0));
    plan.push_back(row(OP_PONG, 4'd0, '0, '0));
    plan.push_back(row(OP_REMOVE, 4'd1, '0, '0, 1'b1,
                       outcome(ST_OK, 4'd1, 1'b0, 5'd1, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_REMOVE, 4'd1, '0, '0, 1'b1,
                       outcome(ST_BAD, 4'd1, 1'b0, 5'd1, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_TOPICS, 4'd1, '0, 7'h7F, 1'b1,
                       outcome(ST_BAD, 4'd1, 1'b0, 5'd1, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_QUERY, 4'd8, '0, '0, 1'b1,
                       outcome(ST_BAD, 4'd8, 1'b0, 5'd1, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_ADD, 4'd0, '1, '0, 1'b1,
                       outcome(ST_OK, 4'd1, 1'b0, 5'd2, 7'h7F, 1'b0, 1'b1)));
    plan.push_back(row(OP_TICK, 4'd0, 64'd0, '0));
    plan.push_back(row(OP_TICK, 4'd0, 64'd1, '0, 1'b1,
                       outcome(ST_OK, 4'd0, 1'b0, 5'd2, '0, 1'b0, 1'b1)));
    plan.push_back(row(OP_PONG, 4'd1, '0, '0));

    foreach (plan[i])
      send_cmd(plan[i].op, plan[i].slot, plan[i].now, plan[i].mask, idle_len(),
               plan[i].typed, plan[i].want);
    directed_items = items_sent;

    // Interval of 1, zero limit, empty default mask; time wraps early on.
    clock_ms = 64'hFFFF_FFFF_FFFF_FFF0;
    reconfigure(32'd1, 8'd0, 7'h00);
    random_phase(PHASE_ITEMS, 1'b1);

    // Zero interval makes every used slot due on every tick.
    reconfigure(32'd0, 8'd254, 7'h55);
    send_cmd(OP_REMOVE, 4'd0, '0, '0, idle_len());
    send_cmd(OP_REMOVE, 4'd1, '0, '0, idle_len());
    send_cmd(OP_ADD, 4'd0, clock_ms, '0, idle_len());
    send_cmd(OP_ADD, 4'd0, clock_ms, '0, idle_len());
    for (int n = 0; n < ZERO_TICKS; n++)
      send_cmd(OP_TICK, 4'($urandom), {$urandom, $urandom}, 7'($urandom), idle_len());

    reconfigure(32'hFFFF_FFFF, 8'd1, 7'h7F);
    random_phase(PHASE_ITEMS, 1'b0);

    quiet = 1'b1;
    reconfigure(32'($urandom_range(2, 300)), 8'($urandom_range(0, 4)), 7'($urandom));
    random_phase(PHASE_ITEMS, 1'b0);
    quiet = 1'b0;

    reconfigure(32'($urandom_range(2, 300)), 8'($urandom_range(0, 4)), 7'($urandom));
    random_phase(PHASE_ITEMS, 1'b0);

    settle();
    $display("Covered %0d commands (%0d directed), %0d results of which %0d were ping notices.",
             items_sent, directed_items, results_seen, ping_results);
    $display("Missed-count saturation reached: %0d; mismatches counted: %0d.",
             saturated_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
